FILE: hdl/vau_pkg.sv
// Shared types, constants and helper functions of the vector arithmetic unit.
`timescale 1ns / 1ps

package vau_pkg;

  // Default word geometry: signed Q16.16.
  localparam int DEF_WORD_BITS     = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Stream widths.
  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 2;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Number of shift-search steps that bring a wide vector into 32 bits.
  localparam int SHIFT_STEPS = 7;
  // Root bits of the square root of a 64-bit sum of squares.
  localparam int SQRT_STEPS  = 32;

  // Operation codes, equal to the action codes of the input beat.
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_NEG    = 4'd2,
    OP_SCALE  = 4'd3,
    OP_DOT    = 4'd4,
    OP_CROSS  = 4'd5,
    OP_UCROSS = 4'd6,
    OP_NORM   = 4'd7,
    OP_MAG    = 4'd8,
    OP_NONE   = 4'd15
  } op_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_e                op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] sf;
  } vau_item_t;

  // Saturated result word with its overflow flag.
  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  // Reads the low ew bits of a word as a signed value.
  function automatic logic signed [31:0] sext_word(input logic [31:0] x, input int ew);
    logic [31:0] t;
    t = x << (32 - ew);
    return $signed(t) >>> (32 - ew);
  endfunction

  // Clamps a wide signed value to the signed ew-bit range.
  function automatic sat_t saturate(input logic signed [65:0] v, input int ew);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    sat_t               r;
    hi    = (66'sd1 <<< (ew - 1)) - 66'sd1;
    lo    = -hi - 66'sd1;
    r.ov  = 1'b0;
    r.val = v[31:0];
    if (v > hi) begin
      r.ov  = 1'b1;
      r.val = hi[31:0];
    end else if (v < lo) begin
      r.ov  = 1'b1;
      r.val = lo[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/vector3_arithmetic_unit.sv
// Top level of the three-component fixed-point vector arithmetic unit.
`timescale 1ns / 1ps

// Takes one beat per cycle while its queue has room, holding two signed
// fixed-point vectors, a scale factor and an action code, and returns one
// beat per input beat in order: sum, difference, negation, scaled vector, dot
// product, cross product, unit cross product, unit vector or magnitude,
// saturated with an overflow flag and a zero-length flag for a vector that
// cannot be normalized. Throughput is one beat per cycle when the output side
// does not stall. The default format is signed Q16.16. Every beat passes
// through the 32-step square root and the FRACTION_BITS + 1 division steps
// of the unit-vector path. A four-entry queue lets the input side keep
// accepting while the output side stalls.
module vector3_arithmetic_unit import vau_pkg::*; #(
  parameter int WORD_BITS     = DEF_WORD_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z, scale_factor
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // result_x, result_y, result_z, result_scalar
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // zero_length, overflow
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  vau_item_t front_item;
  vau_item_t queue_item;
  logic      push;
  logic      full;
  logic      queue_valid;
  logic      back_ready;

  vau_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (front_item)
  );

  vau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (back_ready),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  vau_back #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (queue_item),
    .item_valid_i    (queue_valid),
    .item_ready_o    (back_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

FILE: hdl/vau_front.sv
// Front end: takes input beats, decodes the action and sign-extends the operands.
`timescale 1ns / 1ps

module vau_front import vau_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z, scale_factor
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // action
  input  logic [IN_USER_W-1:0] s_axis_tuser_i,
  input  logic                 full_i,
  output logic                 push_o,
  output vau_item_t            item_o
);

  localparam int EW = (WORD_BITS < 32) ? WORD_BITS : 32;

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  // Operand fields read at the effective word width, then the action decode;
  // unused codes become a no-op that yields all zeros.
  always_comb begin
    item_o.ax = sext_word(s_axis_tdata_i[31:0], EW);
    item_o.ay = sext_word(s_axis_tdata_i[63:32], EW);
    item_o.az = sext_word(s_axis_tdata_i[95:64], EW);
    item_o.bx = sext_word(s_axis_tdata_i[127:96], EW);
    item_o.by = sext_word(s_axis_tdata_i[159:128], EW);
    item_o.bz = sext_word(s_axis_tdata_i[191:160], EW);
    item_o.sf = sext_word(s_axis_tdata_i[223:192], EW);
    unique case (s_axis_tuser_i) inside
      OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_DOT,
      OP_CROSS, OP_UCROSS, OP_NORM, OP_MAG: item_o.op = op_e'(s_axis_tuser_i);
      default:                              item_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: hdl/vau_queue.sv
// Short first-in first-out queue that decouples the front from the back.
`timescale 1ns / 1ps

module vau_queue import vau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vau_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output vau_item_t item_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  vau_item_t     mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == (AW + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill level update.
  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(QUEUE_DEPTH))
    else $error("queue fill level beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level did not follow a lone write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wptr_q == rptr_q))
    else $error("empty queue with pointers apart");

endmodule

FILE: hdl/vau_back.sv
// Back end: pipelined products, shift search, square root, division and output register.
`timescale 1ns / 1ps

module vau_back import vau_pkg::*; #(
  parameter int WORD_BITS     = DEF_WORD_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vau_item_t             item_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  localparam int EW     = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int ND     = FRACTION_BITS + 1;
  localparam int DW     = FRACTION_BITS + 34;
  localparam int ST_MAG = 2;
  localparam int ST_SH0 = 3;
  localparam int ST_SQ  = ST_SH0 + SHIFT_STEPS;
  localparam int ST_SUM = ST_SQ + 1;
  localparam int ST_RT0 = ST_SUM + 1;
  localparam int ST_DV0 = ST_RT0 + SQRT_STEPS;
  localparam int ST_OUT = ST_DV0 + ND;
  localparam int NST    = ST_OUT + 1;

  localparam logic [65:0] MAG_LIMIT = 66'd2147483648;

  // Per-item control and early results carried along the whole pipeline.
  typedef struct packed {
    op_e             op;
    logic [31:0]     rx;
    logic [31:0]     ry;
    logic [31:0]     rz;
    logic [31:0]     rs;
    logic            ov;
    logic [2:0]      neg;
    logic            zl;
    logic [2:0][31:0] mn;
  } carry_t;

  logic [NST-1:0]     vld_q;
  logic               adv;
  carry_t             car_q [NST];
  carry_t             car_d [NST];
  logic signed [63:0] prod_q [6];
  logic signed [63:0] prod_d [6];
  logic signed [65:0] lin_q [3];
  logic signed [65:0] lin_d [3];
  logic signed [65:0] vraw_q [3];
  logic signed [65:0] vraw_d [3];
  logic signed [65:0] sraw_q, sraw_d;
  logic [65:0]        m_q [ST_MAG:ST_SQ-1][3];
  logic [65:0]        m_d [ST_MAG:ST_SQ-1][3];
  logic [63:0]        sq_q [3];
  logic [63:0]        sq_d [3];
  logic [63:0]        rem_q [ST_SUM:ST_DV0-1];
  logic [63:0]        rem_d [ST_SUM:ST_DV0-1];
  logic [31:0]        root_q [ST_SUM:ST_OUT-1];
  logic [31:0]        root_d [ST_SUM:ST_OUT-1];
  logic [DW-1:0]      drem_q [ST_DV0-1:ST_OUT-1][3];
  logic [DW-1:0]      drem_d [ST_DV0-1:ST_OUT-1][3];
  logic [ND-1:0]      quo_q [ST_DV0-1:ST_OUT-1][3];
  logic [ND-1:0]      quo_d [ST_DV0-1:ST_OUT-1][3];

  assign adv          = !vld_q[NST-1] || m_axis_tready_i;
  assign item_ready_o = adv;

  // Datapath of every stage.
  always_comb begin
    logic signed [31:0] mul_a [6];
    logic signed [31:0] mul_b [6];
    logic signed [63:0] sh [6];
    sat_t               sat_e [4];
    sat_t               sat_o [4];
    logic               any_big;
    logic [64:0]        trial;
    logic [DW-1:0]      dv;
    logic signed [65:0] uq;
    logic               norm_op;
    int                 st;
    int                 amt;
    int                 tst;
    int                 k;
    int                 bit_pos;

    // Stage 0: operand selection and the six products.
    car_d[0]    = '0;
    car_d[0].op = item_i.op;
    mul_a[0] = item_i.ay; mul_b[0] = item_i.bz;
    mul_a[1] = item_i.az; mul_b[1] = item_i.by;
    mul_a[2] = item_i.az; mul_b[2] = item_i.bx;
    mul_a[3] = item_i.ax; mul_b[3] = item_i.bz;
    mul_a[4] = item_i.ax; mul_b[4] = item_i.by;
    mul_a[5] = item_i.ay; mul_b[5] = item_i.bx;
    case (item_i.op)
      OP_SCALE: begin
        mul_a[0] = item_i.ax; mul_b[0] = item_i.sf;
        mul_a[1] = item_i.ay; mul_b[1] = item_i.sf;
        mul_a[2] = item_i.az; mul_b[2] = item_i.sf;
      end
      OP_DOT: begin
        mul_a[0] = item_i.ax; mul_b[0] = item_i.bx;
        mul_a[1] = item_i.ay; mul_b[1] = item_i.by;
        mul_a[2] = item_i.az; mul_b[2] = item_i.bz;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      prod_d[i] = 64'(mul_a[i]) * 64'(mul_b[i]);
    end
    lin_d[0] = 66'(item_i.ax);
    lin_d[1] = 66'(item_i.ay);
    lin_d[2] = 66'(item_i.az);
    case (item_i.op)
      OP_ADD: begin
        lin_d[0] = 66'(item_i.ax) + 66'(item_i.bx);
        lin_d[1] = 66'(item_i.ay) + 66'(item_i.by);
        lin_d[2] = 66'(item_i.az) + 66'(item_i.bz);
      end
      OP_SUB: begin
        lin_d[0] = 66'(item_i.ax) - 66'(item_i.bx);
        lin_d[1] = 66'(item_i.ay) - 66'(item_i.by);
        lin_d[2] = 66'(item_i.az) - 66'(item_i.bz);
      end
      OP_NEG: begin
        lin_d[0] = -66'(item_i.ax);
        lin_d[1] = -66'(item_i.ay);
        lin_d[2] = -66'(item_i.az);
      end
      default: begin
      end
    endcase

    // Stage 1: fixed-point products combined into vector or scalar.
    car_d[1] = car_q[0];
    for (int i = 0; i < 6; i++) begin
      sh[i] = prod_q[i] >>> FRACTION_BITS;
    end
    for (int i = 0; i < 3; i++) begin
      vraw_d[i] = lin_q[i];
    end
    sraw_d = '0;
    case (car_q[0].op) inside
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          vraw_d[i] = 66'(sh[i]);
        end
      end
      OP_DOT: begin
        sraw_d = 66'(sh[0]) + 66'(sh[1]) + 66'(sh[2]);
      end
      OP_CROSS, OP_UCROSS: begin
        vraw_d[0] = 66'(sh[0]) - 66'(sh[1]);
        vraw_d[1] = 66'(sh[2]) - 66'(sh[3]);
        vraw_d[2] = 66'(sh[4]) - 66'(sh[5]);
      end
      default: begin
      end
    endcase

    // Stage 2: saturate direct results, take magnitudes for the root path.
    car_d[2]    = car_q[1];
    car_d[2].rx = '0;
    car_d[2].ry = '0;
    car_d[2].rz = '0;
    car_d[2].rs = '0;
    car_d[2].ov = 1'b0;
    for (int i = 0; i < 3; i++) begin
      car_d[2].neg[i] = vraw_q[i][65];
      m_d[ST_MAG][i]  = vraw_q[i][65] ? 66'(-vraw_q[i]) : 66'(vraw_q[i]);
      sat_e[i]        = saturate(vraw_q[i], EW);
    end
    sat_e[3] = saturate(sraw_q, EW);
    case (car_q[1].op) inside
      OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS: begin
        car_d[2].rx = sat_e[0].val;
        car_d[2].ry = sat_e[1].val;
        car_d[2].rz = sat_e[2].val;
        car_d[2].ov = sat_e[0].ov | sat_e[1].ov | sat_e[2].ov;
      end
      OP_DOT: begin
        car_d[2].rs = sat_e[3].val;
        car_d[2].ov = sat_e[3].ov;
      end
      default: begin
      end
    endcase

    // Shift search: binary steps, then one last single-bit step.
    for (int j = 0; j < SHIFT_STEPS; j++) begin
      st       = ST_SH0 + j;
      amt      = (j < SHIFT_STEPS - 1) ? (1 << (SHIFT_STEPS - 2 - j)) : 1;
      tst      = (j < SHIFT_STEPS - 1) ? amt : 0;
      car_d[st] = car_q[st-1];
      any_big  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        any_big = any_big | ((m_q[st-1][i] >> tst) > MAG_LIMIT);
      end
      for (int i = 0; i < 3; i++) begin
        m_d[st][i] = any_big ? (m_q[st-1][i] >> amt) : m_q[st-1][i];
      end
    end

    // Squares of the reduced magnitudes.
    car_d[ST_SQ] = car_q[ST_SQ-1];
    for (int i = 0; i < 3; i++) begin
      car_d[ST_SQ].mn[i] = m_q[ST_SQ-1][i][31:0];
      sq_d[i] = 64'(m_q[ST_SQ-1][i][31:0]) * 64'(m_q[ST_SQ-1][i][31:0]);
    end

    // Sum of squares; it seeds the square root.
    car_d[ST_SUM]    = car_q[ST_SUM-1];
    rem_d[ST_SUM]    = sq_q[0] + sq_q[1] + sq_q[2];
    root_d[ST_SUM]   = '0;
    car_d[ST_SUM].zl = (rem_d[ST_SUM] == '0);

    // Square root, one root bit per stage from the top.
    for (int t = 0; t < SQRT_STEPS; t++) begin
      st        = ST_RT0 + t;
      k         = SQRT_STEPS - 1 - t;
      car_d[st] = car_q[st-1];
      trial     = (65'(root_q[st-1]) << (k + 1)) + (65'd1 << (2 * k));
      if ({1'b0, rem_q[st-1]} >= trial) begin
        rem_d[st]  = rem_q[st-1] - trial[63:0];
        root_d[st] = root_q[st-1] | (32'd1 << k);
      end else begin
        rem_d[st]  = rem_q[st-1];
        root_d[st] = root_q[st-1];
      end
    end

    // Dividend of each lane, set up beside the last root step.
    for (int i = 0; i < 3; i++) begin
      drem_d[ST_DV0-1][i] = DW'(car_q[ST_DV0-2].mn[i]) << FRACTION_BITS;
      quo_d[ST_DV0-1][i]  = '0;
    end

    // Restoring division of the three lanes by the length.
    for (int u = 0; u < ND; u++) begin
      st         = ST_DV0 + u;
      bit_pos    = FRACTION_BITS - u;
      car_d[st]  = car_q[st-1];
      root_d[st] = root_q[st-1];
      dv         = DW'(root_q[st-1]) << bit_pos;
      for (int i = 0; i < 3; i++) begin
        if (drem_q[st-1][i] >= dv) begin
          drem_d[st][i] = drem_q[st-1][i] - dv;
          quo_d[st][i]  = quo_q[st-1][i] | (ND'(1) << bit_pos);
        end else begin
          drem_d[st][i] = drem_q[st-1][i];
          quo_d[st][i]  = quo_q[st-1][i];
        end
      end
    end

    // Output stage: pick the result of the root path where it applies.
    car_d[ST_OUT] = car_q[ST_OUT-1];
    norm_op = (car_q[ST_OUT-1].op == OP_UCROSS) || (car_q[ST_OUT-1].op == OP_NORM);
    for (int i = 0; i < 3; i++) begin
      uq = car_q[ST_OUT-1].neg[i] ? -66'(quo_q[ST_OUT-1][i]) : 66'(quo_q[ST_OUT-1][i]);
      sat_o[i] = saturate(uq, EW);
    end
    sat_o[3] = saturate(66'(root_q[ST_OUT-1]), EW);
    if (norm_op) begin
      car_d[ST_OUT].rs = '0;
      if (car_q[ST_OUT-1].zl) begin
        car_d[ST_OUT].rx = '0;
        car_d[ST_OUT].ry = '0;
        car_d[ST_OUT].rz = '0;
        car_d[ST_OUT].ov = 1'b0;
      end else begin
        car_d[ST_OUT].rx = sat_o[0].val;
        car_d[ST_OUT].ry = sat_o[1].val;
        car_d[ST_OUT].rz = sat_o[2].val;
        car_d[ST_OUT].ov = sat_o[0].ov | sat_o[1].ov | sat_o[2].ov;
      end
    end else begin
      car_d[ST_OUT].zl = 1'b0;
      if (car_q[ST_OUT-1].op == OP_MAG) begin
        car_d[ST_OUT].rs = sat_o[3].val;
        car_d[ST_OUT].ov = sat_o[3].ov;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], item_valid_i};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      car_q  <= car_d;
      prod_q <= prod_d;
      lin_q  <= lin_d;
      vraw_q <= vraw_d;
      sraw_q <= sraw_d;
      m_q    <= m_d;
      sq_q   <= sq_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      drem_q <= drem_d;
      quo_q  <= quo_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tdata_o  = {car_q[NST-1].rs, car_q[NST-1].rz,
                            car_q[NST-1].ry, car_q[NST-1].rx};
  assign m_axis_tuser_o  = {car_q[NST-1].ov, car_q[NST-1].zl};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && car_q[NST-1].zl) |->
      (car_q[NST-1].rx == '0 && car_q[NST-1].ry == '0 &&
       car_q[NST-1].rz == '0 && !car_q[NST-1].ov))
    else $error("zero length beat with a nonzero vector or overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && car_q[NST-1].op == OP_MAG) |->
      (car_q[NST-1].rx == '0 && car_q[NST-1].ry == '0 &&
       car_q[NST-1].rz == '0 && !car_q[NST-1].zl))
    else $error("magnitude beat carries a vector");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && car_q[NST-1].op == OP_NONE) |->
      (m_axis_tdata_o == '0 && m_axis_tuser_o == '0))
    else $error("unused action produced a nonzero beat");

endmodule
